[rtl/core/arsx_pkg.sv]
// Shared constants, types and elaboration-time functions for the affine
// rotation/scale extractor. No dependencies.
package arsx_pkg;

  localparam int COEF_W        = 32;
  localparam int SCALE_W       = 32;
  localparam int ANGLE_W       = 19;
  localparam int OUT_FRAC      = 16;
  localparam int CORDIC_STEPS  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int GUARD_SHIFT   = 24;
  localparam int CORDIC_W      = 64;
  localparam int ZW            = FRACTION_BITS + 4;
  localparam int ROOT_BITS     = 32;

  // Pipeline depths: both datapaths line up at SQRT_LAT.
  localparam int SQRT_LAT  = ROOT_BITS + 4;
  localparam int ANGLE_LAT = CORDIC_STEPS + 4;
  localparam int PAD_LAT   = SQRT_LAT - ANGLE_LAT;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  function automatic logic [63:0] round_q(input logic [63:0] v, input int s);
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  // Restoring long division, used only on constants at elaboration.
  function automatic logic [63:0] udiv_const(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[62:0], num[j]};
      if (rem >= den) begin
        rem = rem - den;
        quo[j] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) scaled by 2^62 as a truncated power series.
  function automatic logic [63:0] atan_q62(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int k;
    int e;
    sum = '0;
    if (i == 0) return PI_Q60;
    k = 0;
    while ((2 * k + 1) * i <= 62) begin
      e = 62 - (2 * k + 1) * i;
      term = udiv_const(64'd1 << e, 64'(2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
      k = k + 1;
    end
    return sum;
  endfunction

  function automatic logic [ZW-1:0] atan_rom(input int i);
    return ZW'(round_q(atan_q62(i), 62 - FRACTION_BITS));
  endfunction

  function automatic logic [COEF_W-1:0] mag32(input logic signed [COEF_W-1:0] v);
    return v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
  endfunction

  localparam logic [63:0] HALF_PI_F  = round_q(PI_Q60, 61 - FRACTION_BITS);
  localparam logic [63:0] PI_F       = round_q(PI_Q60, 60 - FRACTION_BITS);
  localparam logic [63:0] TWO_PI_F   = round_q(PI_Q60, 59 - FRACTION_BITS);
  localparam logic [63:0] TWO_PI_OUT = round_q(PI_Q60, 59 - OUT_FRAC);

  localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_F);
  localparam logic signed [ZW-1:0] PI_Z      = ZW'(PI_F);
  localparam logic signed [ZW-1:0] TWO_PI_Z  = ZW'(TWO_PI_F);

endpackage

[rtl/core/arsx_if.sv]
// Valid/ready channel interfaces for the coefficient requests and the results.
// Standalone; payload widths follow the fixed field widths.
interface arsx_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;
  logic signed [31:0] coef_d;

  modport source(output valid, coef_a, coef_b, coef_c, coef_d, input ready);
  modport sink(input valid, coef_a, coef_b, coef_c, coef_d, output ready);
endinterface

interface arsx_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] rotation_angle;
  logic [31:0] scale_x;
  logic [31:0] scale_y;
  logic        degenerate;

  modport source(output valid, rotation_angle, scale_x, scale_y, degenerate, input ready);
  modport sink(input valid, rotation_angle, scale_x, scale_y, degenerate, output ready);
endinterface

[rtl/core/affine_rotation_scale_extract_unit.sv]
// Throughput: one request per cycle while the skid register is empty; the 32-stage
// bit-per-stage square root sets the pipeline depth.
// When the output stalls, one result moves to a skid register and the pipeline then
// freezes as a whole until it drains; requests are taken whenever the skid is empty.
// Reset (synchronous) clears all valid bits and the skid; data registers are not reset.
// Top level; depends on arsx_pkg, arsx_if, arsx_sqrt and arsx_angle.
module affine_rotation_scale_extract_unit import arsx_pkg::*; (
  input logic        clk,
  input logic        rst,
  arsx_in_if.sink    coef,
  arsx_out_if.source result
);

  pipe_ctl_t          ctl;
  logic               vx, vy, va;
  logic [SCALE_W-1:0] len_x, len_y;
  logic [ANGLE_W-1:0] ang;
  logic               dg;

  logic               skid_valid;
  logic [ANGLE_W-1:0] sk_ang;
  logic [SCALE_W-1:0] sk_x, sk_y;
  logic               sk_dg;

  // Packed order is en, then valid.
  assign ctl        = {~skid_valid, coef.valid};
  assign coef.ready = ~skid_valid;

  arsx_sqrt u_len_x (
    .clk (clk), .rst (rst), .ctl (ctl),
    .p   (coef.coef_a), .q (coef.coef_b),
    .vld (vx), .len (len_x)
  );

  arsx_sqrt u_len_y (
    .clk (clk), .rst (rst), .ctl (ctl),
    .p   (coef.coef_c), .q (coef.coef_d),
    .vld (vy), .len (len_y)
  );

  arsx_angle u_angle (
    .clk (clk), .rst (rst), .ctl (ctl),
    .a   (coef.coef_a), .b (coef.coef_b),
    .vld (va), .angle (ang), .degen (dg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) skid_valid <= 1'b0;
    end else if (vx && !result.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      sk_ang <= ang;
      sk_x   <= len_x;
      sk_y   <= len_y;
      sk_dg  <= dg;
    end
  end

  // The skid holds the older result, so it goes out first.
  assign result.valid          = skid_valid | vx;
  assign result.rotation_angle = skid_valid ? sk_ang : ang;
  assign result.scale_x        = skid_valid ? sk_x : len_x;
  assign result.scale_y        = skid_valid ? sk_y : len_y;
  assign result.degenerate     = skid_valid ? sk_dg : dg;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (vx == vy) && (vx == va))
    else $error("length and angle pipelines are out of step");

  a_skid_load: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(vx && !result.ready))
    else $error("skid loaded without a stalled result");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.rotation_angle < ANGLE_W'(TWO_PI_OUT)))
    else $error("rotation angle at or above 2pi");

  a_degen_angle: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.degenerate) |->
      (result.rotation_angle == '0) && (result.scale_x == '0))
    else $error("degenerate result with nonzero angle or x scale");

endmodule

[rtl/core/arsx_sqrt.sv]
// Pipelined vector length: |p|, squares, sum, one root bit per stage, rounding.
// Depends on arsx_pkg.
module arsx_sqrt import arsx_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  pipe_ctl_t                ctl,
  input  logic signed [COEF_W-1:0] p,
  input  logic signed [COEF_W-1:0] q,
  output logic                     vld,
  output logic [SCALE_W-1:0]       len
);

  logic [COEF_W-1:0]    mp, mq;
  logic [63:0]          sp, sq;
  logic                 v1, v2;
  logic [63:0]          rem_s  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] root_s [ROOT_BITS+1];
  logic                 v_s    [ROOT_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v_s[0] <= 1'b0;
    end else if (ctl.en) begin
      v1     <= ctl.valid;
      v2     <= v1;
      v_s[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      mp        <= mag32(p);
      mq        <= mag32(q);
      sp        <= mp * mp;
      sq        <= mq * mq;
      rem_s[0]  <= sp + sq;
      root_s[0] <= '0;
    end
  end

  // Each stage decides one root bit, most significant first.
  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_bit
    localparam int K = ROOT_BITS - 1 - g;
    logic [65:0] trial;

    assign trial = ({34'd0, root_s[g]} << (K + 1)) + (66'd1 << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[g+1] <= 1'b0;
      end else if (ctl.en) begin
        v_s[g+1] <= v_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        if ({2'b00, rem_s[g]} >= trial) begin
          rem_s[g+1]  <= rem_s[g] - trial[63:0];
          root_s[g+1] <= root_s[g] | (ROOT_BITS'(1) << K);
        end else begin
          rem_s[g+1]  <= rem_s[g];
          root_s[g+1] <= root_s[g];
        end
      end
    end
  end

  // The remainder is n - root^2, so rounding up means remainder > root.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.en) begin
      vld <= v_s[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      len <= ({32'd0, root_s[ROOT_BITS]} < rem_s[ROOT_BITS]) ?
             root_s[ROOT_BITS] + 1'b1 : root_s[ROOT_BITS];
    end
  end

endmodule

[rtl/core/arsx_angle.sv]
// Pipelined atan2(b, a) in [0, 2pi): CORDIC vectoring, quadrant fold, wrap,
// rounding to Q3.16 and a delay line to match the length pipeline. Uses arsx_pkg.
module arsx_angle import arsx_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  pipe_ctl_t                ctl,
  input  logic signed [COEF_W-1:0] a,
  input  logic signed [COEF_W-1:0] b,
  output logic                     vld,
  output logic [ANGLE_W-1:0]       angle,
  output logic                     degen
);

  typedef struct packed {
    logic a_neg;
    logic b_neg;
    logic a_zero;
    logic b_zero;
  } quad_t;

  localparam int EW = ZW + OUT_FRAC + 1;

  logic signed [CORDIC_W-1:0] x_s [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y_s [CORDIC_STEPS+1];
  logic signed [ZW-1:0]       z_s [CORDIC_STEPS+1];
  quad_t                      f_s [CORDIC_STEPS+1];
  logic                       v_s [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (ctl.en) begin
      v_s[0] <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      x_s[0]        <= CORDIC_W'(mag32(a)) << GUARD_SHIFT;
      y_s[0]        <= CORDIC_W'(mag32(b)) << GUARD_SHIFT;
      z_s[0]        <= '0;
      f_s[0].a_neg  <= a[COEF_W-1];
      f_s[0].b_neg  <= b[COEF_W-1];
      f_s[0].a_zero <= (a == '0);
      f_s[0].b_zero <= (b == '0);
    end
  end

  // One micro-rotation per stage; the arithmetic shift floors toward minus infinity.
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    localparam logic signed [ZW-1:0] AT = atan_rom(g);
    logic signed [CORDIC_W-1:0] xs, ys;

    assign xs = x_s[g] >>> g;
    assign ys = y_s[g] >>> g;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[g+1] <= 1'b0;
      end else if (ctl.en) begin
        v_s[g+1] <= v_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        f_s[g+1] <= f_s[g];
        if (!y_s[g][CORDIC_W-1]) begin
          x_s[g+1] <= x_s[g] + ys;
          y_s[g+1] <= y_s[g] - xs;
          z_s[g+1] <= z_s[g] + AT;
        end else begin
          x_s[g+1] <= x_s[g] - ys;
          y_s[g+1] <= y_s[g] + xs;
          z_s[g+1] <= z_s[g] - AT;
        end
      end
    end
  end

  quad_t                f;
  logic signed [ZW-1:0] zc, r, rw;
  logic signed [ZW-1:0] r_f;
  logic [ZW-1:0]        w_f;
  logic                 v_fold, v_wrap, v_rnd;
  logic                 dg_fold, dg_wrap, dg_rnd;
  logic [ANGLE_W-1:0]   ang_r;
  logic [EW-1:0]        ext, rnd;

  assign f = f_s[CORDIC_STEPS];

  // Clamp to [0, pi/2] and fold into the quadrant of (a, b); axis cases are exact.
  always_comb begin
    zc = z_s[CORDIC_STEPS];
    if (zc[ZW-1]) zc = '0;
    else if (zc > HALF_PI_Z) zc = HALF_PI_Z;

    priority if (f.a_zero && f.b_zero) r = '0;
    else if (f.b_zero) r = f.a_neg ? PI_Z : '0;
    else if (f.a_zero) r = f.b_neg ? PI_Z + HALF_PI_Z : HALF_PI_Z;
    else if (!f.a_neg && !f.b_neg) r = zc;
    else if (f.a_neg && !f.b_neg) r = PI_Z - zc;
    else if (f.a_neg) r = PI_Z + zc;
    else r = TWO_PI_Z - zc;
  end

  always_comb begin
    rw = (r_f >= TWO_PI_Z) ? r_f - TWO_PI_Z : r_f;
    if (rw[ZW-1]) rw = '0;
  end

  assign ext = EW'(w_f);

  if (FRACTION_BITS > OUT_FRAC) begin : g_down
    assign rnd = (ext + (EW'(1) << (FRACTION_BITS - OUT_FRAC - 1)))
                 >> (FRACTION_BITS - OUT_FRAC);
  end else begin : g_up
    assign rnd = ext << (OUT_FRAC - FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_fold <= 1'b0;
      v_wrap <= 1'b0;
      v_rnd  <= 1'b0;
    end else if (ctl.en) begin
      v_fold <= v_s[CORDIC_STEPS];
      v_wrap <= v_fold;
      v_rnd  <= v_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      r_f     <= r;
      dg_fold <= f.a_zero && f.b_zero;
      w_f     <= rw;
      dg_wrap <= dg_fold;
      // A value that rounds up to 2pi wraps to zero.
      ang_r   <= (rnd >= EW'(TWO_PI_OUT)) ? '0 : rnd[ANGLE_W-1:0];
      dg_rnd  <= dg_wrap;
    end
  end

  if (PAD_LAT > 0) begin : g_pad
    logic [ANGLE_W-1:0] pd_ang [PAD_LAT];
    logic               pd_dg  [PAD_LAT];
    logic               pd_v   [PAD_LAT];

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int j = 0; j < PAD_LAT; j++) pd_v[j] <= 1'b0;
      end else if (ctl.en) begin
        pd_v[0] <= v_rnd;
        for (int j = 1; j < PAD_LAT; j++) pd_v[j] <= pd_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        pd_ang[0] <= ang_r;
        pd_dg[0]  <= dg_rnd;
        for (int j = 1; j < PAD_LAT; j++) begin
          pd_ang[j] <= pd_ang[j-1];
          pd_dg[j]  <= pd_dg[j-1];
        end
      end
    end

    assign vld   = pd_v[PAD_LAT-1];
    assign angle = pd_ang[PAD_LAT-1];
    assign degen = pd_dg[PAD_LAT-1];
  end else begin : g_nopad
    assign vld   = v_rnd;
    assign angle = ang_r;
    assign degen = dg_rnd;
  end

endmodule
